// ===== rtl/hysl_pkg.sv =====
// Shared types, constants and the arctangent table for the heading yaw slew limiter.
`timescale 1ns / 1ps

package hysl_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANG_PI           = 25736;
	localparam int ANG_HALF_PI      = 12868;
	localparam int ANG_TWO_PI       = 51472;
	localparam int PRESHIFT         = 6;
	localparam int POS_W            = 24;
	localparam int DELTA_W          = POS_W + 1;
	localparam int CW               = 34;
	localparam int ZW               = 19;

	typedef enum logic {
		REG_YAW_STEP    = 1'b0,
		REG_NEAR_RADIUS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ALPHA_CORDIC  = 2'd0,
		ALPHA_ZERO    = 2'd1,
		ALPHA_HALF_PI = 2'd2
	} alpha_src_t;

	typedef struct packed {
		logic                 dx_neg;
		logic                 dy_neg;
		logic                 near;
		alpha_src_t           alpha_src;
		logic signed [15:0]   yaw;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	// Arctangent of 2^-i in units of 2^-16 rad.
	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] val;
		case (i)
			0:       val = ZW'(51472);
			1:       val = ZW'(30386);
			2:       val = ZW'(16055);
			3:       val = ZW'(8150);
			4:       val = ZW'(4091);
			5:       val = ZW'(2047);
			6:       val = ZW'(1024);
			7:       val = ZW'(512);
			8:       val = ZW'(256);
			9:       val = ZW'(128);
			10:      val = ZW'(64);
			11:      val = ZW'(32);
			12:      val = ZW'(16);
			13:      val = ZW'(8);
			14:      val = ZW'(4);
			15:      val = ZW'(2);
			16:      val = ZW'(1);
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== rtl/hysl_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
`timescale 1ns / 1ps

interface hysl_req_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] cur_x;
	logic signed [23:0] cur_y;
	logic signed [15:0] cur_yaw;
	logic signed [23:0] tgt_x;
	logic signed [23:0] tgt_y;

	modport source (output valid, cur_x, cur_y, cur_yaw, tgt_x, tgt_y, input ready);
	modport sink (input valid, cur_x, cur_y, cur_yaw, tgt_x, tgt_y, output ready);
endinterface

interface hysl_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] yaw_cmd;
	logic signed [15:0] heading;
	logic               near_target;

	modport source (output valid, yaw_cmd, heading, near_target, input ready);
	modport sink (input valid, yaw_cmd, heading, near_target, output ready);
endinterface

// ===== rtl/hysl_front.sv =====
// Front end: position deltas, magnitudes, near-box test and CORDIC seed.
`timescale 1ns / 1ps

module hysl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] cur_x,
	input  logic signed [23:0] cur_y,
	input  logic signed [15:0] cur_yaw,
	input  logic signed [23:0] tgt_x,
	input  logic signed [23:0] tgt_y,
	input  logic [15:0]        near_radius,
	output logic               out_valid,
	input  logic               out_ready,
	output hysl_pkg::vec_t     out_vec,
	output hysl_pkg::side_t    out_side
);
	import hysl_pkg::*;

	logic                      v_s1;
	logic signed [DELTA_W-1:0] dx_s1;
	logic signed [DELTA_W-1:0] dy_s1;
	logic signed [15:0]        yaw_s1;
	logic                      v_s2;
	vec_t                      vec_s2;
	side_t                     side_s2;
	logic                      en_s1;
	logic                      en_s2;
	logic [DELTA_W-1:0]        adx;
	logic [DELTA_W-1:0]        ady;
	logic [POS_W-1:0]          ax;
	logic [POS_W-1:0]          ay;
	vec_t                      vec_d;
	side_t                     side_d;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dx_s1  <= DELTA_W'(tgt_x) - DELTA_W'(cur_x);
			dy_s1  <= DELTA_W'(tgt_y) - DELTA_W'(cur_y);
			yaw_s1 <= cur_yaw;
		end
		if (en_s2 && v_s1) begin
			vec_s2  <= vec_d;
			side_s2 <= side_d;
		end
	end

	always_comb begin
		adx = dx_s1[DELTA_W-1] ? DELTA_W'(-dx_s1) : DELTA_W'(dx_s1);
		ady = dy_s1[DELTA_W-1] ? DELTA_W'(-dy_s1) : DELTA_W'(dy_s1);
		ax  = adx[POS_W-1:0];
		ay  = ady[POS_W-1:0];

		vec_d.x = {{(CW-POS_W-PRESHIFT){1'b0}}, ax, {PRESHIFT{1'b0}}};
		vec_d.y = {{(CW-POS_W-PRESHIFT){1'b0}}, ay, {PRESHIFT{1'b0}}};
		vec_d.z = '0;

		side_d.dx_neg = dx_s1[DELTA_W-1];
		side_d.dy_neg = dy_s1[DELTA_W-1];
		side_d.near   = (ax < POS_W'(near_radius)) && (ay < POS_W'(near_radius));
		side_d.yaw    = yaw_s1;
		if (ax == '0 && ay == '0) begin
			side_d.alpha_src = ALPHA_ZERO;
		end else if (ax == '0) begin
			side_d.alpha_src = ALPHA_HALF_PI;
		end else if (ay == '0) begin
			side_d.alpha_src = ALPHA_ZERO;
		end else begin
			side_d.alpha_src = ALPHA_CORDIC;
		end
	end

	assign out_valid = v_s2;
	assign out_vec   = vec_s2;
	assign out_side  = side_s2;

endmodule

// ===== rtl/hysl_cordic.sv =====
// Vectoring CORDIC, one rotation per pipeline stage.
`timescale 1ns / 1ps

module hysl_cordic #(
	parameter int CORDIC_STEPS = hysl_pkg::CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hysl_pkg::vec_t  in_vec,
	input  hysl_pkg::side_t in_side,
	output logic            out_valid,
	input  logic            out_ready,
	output hysl_pkg::vec_t  out_vec,
	output hysl_pkg::side_t out_side
);
	import hysl_pkg::*;

	logic  vld_s  [CORDIC_STEPS];
	vec_t  vec_s  [CORDIC_STEPS];
	side_t side_s [CORDIC_STEPS];
	logic  stg_en [CORDIC_STEPS+1];

	assign stg_en[CORDIC_STEPS] = out_ready;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
		vec_t  prev;
		vec_t  nxt;
		side_t prev_side;
		logic  prev_v;

		if (k == 0) begin : g_first
			assign prev      = in_vec;
			assign prev_side = in_side;
			assign prev_v    = in_valid;
		end else begin : g_next
			assign prev      = vec_s[k-1];
			assign prev_side = side_s[k-1];
			assign prev_v    = vld_s[k-1];
		end

		always_comb begin
			if (prev.y > 0) begin
				nxt.x = prev.x + (prev.y >>> k);
				nxt.y = prev.y - (prev.x >>> k);
				nxt.z = prev.z + atan_lut(k);
			end else begin
				nxt.x = prev.x - (prev.y >>> k);
				nxt.y = prev.y + (prev.x >>> k);
				nxt.z = prev.z - atan_lut(k);
			end
		end

		assign stg_en[k] = !vld_s[k] || stg_en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (stg_en[k]) begin
				vld_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (stg_en[k] && prev_v) begin
				vec_s[k]  <= nxt;
				side_s[k] <= prev_side;
			end
		end
	end

	assign in_ready  = stg_en[0];
	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign out_vec   = vec_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];

endmodule

// ===== rtl/hysl_back.sv =====
// Back end: angle rounding, quadrant mapping, unwrap, slew limit and output register.
`timescale 1ns / 1ps

module hysl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hysl_pkg::vec_t     in_vec,
	input  hysl_pkg::side_t    in_side,
	input  logic [13:0]        yaw_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] yaw_cmd,
	output logic signed [15:0] heading,
	output logic               near_target
);
	import hysl_pkg::*;

	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic                 v_s4;
	logic [13:0]          alpha_s1;
	side_t                side_s1;
	logic signed [15:0]   head_s2;
	side_t                side_s2;
	logic signed [15:0]   head_s3;
	logic signed [17:0]   tgt_s3;
	side_t                side_s3;
	logic signed [16:0]   cmd_s4;
	logic signed [15:0]   head_s4;
	logic signed [15:0]   yaw_s4;
	logic                 near_s4;
	logic                 en_s1;
	logic                 en_s2;
	logic                 en_s3;
	logic                 en_s4;
	logic signed [ZW-1:0] z_rnd;
	logic [13:0]          alpha_d;
	logic signed [15:0]   alpha_sx;
	logic signed [15:0]   head_d;
	logic signed [16:0]   wrap_diff;
	logic signed [17:0]   tgt_d;
	logic signed [18:0]   slew_diff;
	logic signed [18:0]   step_ext;
	logic signed [16:0]   step_17;
	logic signed [16:0]   cmd_d;
	logic signed [18:0]   out_diff;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Round the accumulated angle to 2^-13 rad and clamp it to the first quadrant.
	always_comb begin
		z_rnd = (in_vec.z + ZW'(4)) >>> 3;
		case (in_side.alpha_src)
			ALPHA_ZERO:    alpha_d = '0;
			ALPHA_HALF_PI: alpha_d = 14'(ANG_HALF_PI);
			ALPHA_CORDIC: begin
				if (z_rnd < 0) begin
					alpha_d = '0;
				end else if (z_rnd > ZW'(ANG_HALF_PI)) begin
					alpha_d = 14'(ANG_HALF_PI);
				end else begin
					alpha_d = z_rnd[13:0];
				end
			end
			default:       alpha_d = '0;
		endcase
	end

	always_comb begin
		alpha_sx = $signed({2'b00, alpha_s1});
		if (!side_s1.dy_neg) begin
			head_d = side_s1.dx_neg ? 16'(ANG_PI) - alpha_sx : alpha_sx;
		end else begin
			head_d = side_s1.dx_neg ? alpha_sx - 16'(ANG_PI) : -alpha_sx;
		end
	end

	always_comb begin
		wrap_diff = 17'(side_s2.yaw) - 17'(head_s2);
		if (wrap_diff >= 17'(ANG_PI)) begin
			tgt_d = 18'(head_s2) + 18'(ANG_TWO_PI);
		end else if (wrap_diff <= -17'(ANG_PI)) begin
			tgt_d = 18'(head_s2) - 18'(ANG_TWO_PI);
		end else begin
			tgt_d = 18'(head_s2);
		end
	end

	always_comb begin
		slew_diff = 19'(side_s3.yaw) - 19'(tgt_s3);
		step_ext  = $signed({5'b0, yaw_step});
		step_17   = $signed({3'b0, yaw_step});
		if (side_s3.near) begin
			cmd_d = 17'(side_s3.yaw);
		end else if (slew_diff >= 0) begin
			cmd_d = (slew_diff > step_ext) ? 17'(side_s3.yaw) - step_17 : 17'(tgt_s3);
		end else begin
			cmd_d = (-slew_diff > step_ext) ? 17'(side_s3.yaw) + step_17 : 17'(tgt_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			alpha_s1 <= alpha_d;
			side_s1  <= in_side;
		end
		if (en_s2 && v_s1) begin
			head_s2 <= head_d;
			side_s2 <= side_s1;
		end
		if (en_s3 && v_s2) begin
			head_s3 <= head_s2;
			tgt_s3  <= tgt_d;
			side_s3 <= side_s2;
		end
		if (en_s4 && v_s3) begin
			cmd_s4  <= cmd_d;
			head_s4 <= head_s3;
			yaw_s4  <= side_s3.yaw;
			near_s4 <= side_s3.near;
		end
	end

	assign out_valid   = v_s4;
	assign yaw_cmd     = cmd_s4;
	assign heading     = head_s4;
	assign near_target = near_s4;

	assign out_diff = 19'(cmd_s4) - 19'(yaw_s4);

	a_near_holds_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && near_s4 |-> cmd_s4 == 17'(yaw_s4))
		else $error("Near-box result does not pass the current yaw through.");

	a_slew_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !near_s4 |-> (out_diff <= step_ext) && (out_diff >= -step_ext))
		else $error("Commanded yaw moves by more than the yaw step.");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (head_s4 >= -16'(ANG_PI)) && (head_s4 <= 16'(ANG_PI)))
		else $error("Heading lies outside plus or minus pi.");

endmodule

// ===== rtl/heading_yaw_slew_limiter.sv =====
// Top level: configuration registers and the front, CORDIC and back pipeline sections.
// A request passes two front stages, one stage per CORDIC rotation and four back stages.
// Throughput is one transfer per cycle while responses are taken; every stage has its own
// valid bit and a stalled response holds only the stages behind it that are full.
// Reset clears all valid bits and loads yaw_step with 819 and near_radius with 300.
`timescale 1ns / 1ps

module heading_yaw_slew_limiter #(
	parameter int CORDIC_STEPS = hysl_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	hysl_req_if.sink           req,
	hysl_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  hysl_pkg::reg_idx_t cfg_idx,
	input  logic [15:0]        cfg_wdata
);
	import hysl_pkg::*;

	logic [13:0] yaw_step_q;
	logic [15:0] near_radius_q;
	logic        fr_valid;
	logic        fr_ready;
	vec_t        fr_vec;
	side_t       fr_side;
	logic        cd_valid;
	logic        cd_ready;
	vec_t        cd_vec;
	side_t       cd_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_step_q    <= 14'd819;
			near_radius_q <= 16'd300;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_YAW_STEP:    yaw_step_q    <= cfg_wdata[13:0];
				REG_NEAR_RADIUS: near_radius_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	hysl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.cur_x       (req.cur_x),
		.cur_y       (req.cur_y),
		.cur_yaw     (req.cur_yaw),
		.tgt_x       (req.tgt_x),
		.tgt_y       (req.tgt_y),
		.near_radius (near_radius_q),
		.out_valid   (fr_valid),
		.out_ready   (fr_ready),
		.out_vec     (fr_vec),
		.out_side    (fr_side)
	);

	hysl_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_vec    (fr_vec),
		.in_side   (fr_side),
		.out_valid (cd_valid),
		.out_ready (cd_ready),
		.out_vec   (cd_vec),
		.out_side  (cd_side)
	);

	hysl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cd_valid),
		.in_ready    (cd_ready),
		.in_vec      (cd_vec),
		.in_side     (cd_side),
		.yaw_step    (yaw_step_q),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.yaw_cmd     (rsp.yaw_cmd),
		.heading     (rsp.heading),
		.near_target (rsp.near_target)
	);

endmodule

// ===== verif/heading_yaw_slew_limiter_chk.sv =====
// Checker for the heading yaw slew limiter: predicts each response and compares it.
`timescale 1ns / 1ps

module heading_yaw_slew_limiter_chk #(
	parameter int CORDIC_STEPS = hysl_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	hysl_req_if                req,
	hysl_rsp_if                rsp,
	input  logic               cfg_we,
	input  hysl_pkg::reg_idx_t cfg_idx,
	input  logic [15:0]        cfg_wdata,
	output int                 n_fail,
	output int                 n_pending
);
	import hysl_pkg::*;

	typedef struct packed {
		logic signed [16:0] yaw_cmd;
		logic signed [15:0] heading;
		logic               near;
	} steer_t;

	// Arctangent of 2^-i in units of 2^-16 rad.
	longint atan_q16 [0:23] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	longint yaw_step_q;
	longint near_radius_q;
	steer_t steer_q[$];
	int     fails;

	function automatic steer_t predict_steering(logic signed [23:0] cx, logic signed [23:0] cy,
			logic signed [15:0] yaw_in, logic signed [23:0] tx, logic signed [23:0] ty);
		longint dx, dy, ax, ay, alpha, head, aim, cmd, yaw, x, y, z, xs, ys;
		logic   near;
		steer_t r;
		dx = longint'(tx) - longint'(cx);
		dy = longint'(ty) - longint'(cy);
		yaw = longint'(yaw_in);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax == 0 && ay == 0) begin
			alpha = 0;
		end else if (ax == 0) begin
			alpha = ANG_HALF_PI;
		end else if (ay == 0) begin
			alpha = 0;
		end else begin
			// Vectoring CORDIC on the magnitudes; all shifts round toward minus infinity.
			x = ax <<< PRESHIFT;
			y = ay <<< PRESHIFT;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_q16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_q16[i];
				end
			end
			alpha = (z + 4) >>> 3;
			if (alpha < 0)
				alpha = 0;
			if (alpha > ANG_HALF_PI)
				alpha = ANG_HALF_PI;
		end
		if (dy >= 0)
			head = (dx >= 0) ? alpha : (ANG_PI - alpha);
		else
			head = (dx < 0) ? (alpha - ANG_PI) : -alpha;
		aim = head;
		if (yaw - aim >= ANG_PI)
			aim = aim + ANG_TWO_PI;
		else if (yaw - aim <= -ANG_PI)
			aim = aim - ANG_TWO_PI;
		if (aim <= yaw)
			cmd = (yaw - aim > yaw_step_q) ? (yaw - yaw_step_q) : aim;
		else
			cmd = (aim - yaw > yaw_step_q) ? (yaw + yaw_step_q) : aim;
		near = (ax < near_radius_q) && (ay < near_radius_q);
		if (near)
			cmd = yaw;
		r.yaw_cmd = 17'(cmd);
		r.heading = 16'(head);
		r.near = near;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		fails++;
		if (fails <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		steer_t exp_r;
		if (!arst_n) begin
			yaw_step_q = 819;
			near_radius_q = 300;
			steer_q.delete();
			fails = 0;
			n_fail <= 0;
			n_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_YAW_STEP: yaw_step_q = longint'(cfg_wdata[13:0]);
					REG_NEAR_RADIUS: near_radius_q = longint'(cfg_wdata);
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (steer_q.size() == 0) begin
					flag_error($sformatf("unexpected response yaw_cmd %0d heading %0d near %0d",
						rsp.yaw_cmd, rsp.heading, rsp.near_target));
				end else begin
					exp_r = steer_q.pop_front();
					if (rsp.yaw_cmd != exp_r.yaw_cmd || rsp.heading != exp_r.heading
							|| rsp.near_target != exp_r.near)
						flag_error($sformatf({"mismatch: yaw_cmd exp %0d got %0d, ",
							"heading exp %0d got %0d, near exp %0d got %0d"},
							exp_r.yaw_cmd, rsp.yaw_cmd, exp_r.heading, rsp.heading,
							exp_r.near, rsp.near_target));
				end
			end
			if (req.valid && req.ready)
				steer_q.insert(steer_q.size(), predict_steering(req.cur_x, req.cur_y,
					req.cur_yaw, req.tgt_x, req.tgt_y));
			n_fail <= fails;
			n_pending <= steer_q.size();
		end
	end

endmodule

// ===== verif/heading_yaw_slew_limiter_tb.sv =====
// Testbench top for the heading yaw slew limiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module heading_yaw_slew_limiter_tb;
	import hysl_pkg::*;

	localparam int MAX_CYCLES = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_ITEMS = 75;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_idx;
	logic [15:0] cfg_wdata;
	logic        hold_go;
	int          hold_left;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          cur_radius;
	int          n_fail;
	int          n_pending;
	int          cycles = 0;

	hysl_req_if req_ch ();
	hysl_rsp_if rsp_ch ();

	heading_yaw_slew_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	heading_yaw_slew_limiter_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.n_fail    (n_fail),
		.n_pending (n_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// A hold-off request keeps the response side stalled long enough to back up the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_go) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
		end else if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp_ch.ready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
		end
	end

	task automatic send_request(input int cx, input int cy, input int yaw, input int tx,
			input int ty);
		while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cur_x <= 24'(cx);
		req_ch.cur_y <= 24'(cy);
		req_ch.cur_yaw <= 16'(yaw);
		req_ch.tgt_x <= 24'(tx);
		req_ch.tgt_y <= 24'(ty);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain_pipeline();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input int step_val, input int radius);
		cfg_we <= 1'b1;
		cfg_idx <= REG_YAW_STEP;
		cfg_wdata <= 16'(step_val);
		@(posedge clk);
		cfg_idx <= REG_NEAR_RADIUS;
		cfg_wdata <= 16'(radius);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_radius = radius;
	endtask

	task automatic send_random_request();
		int cx, cy, tx, ty, dx, dy, yaw, kind;
		cx = int'($urandom_range(0, 16777215)) - 8388608;
		cy = int'($urandom_range(0, 16777215)) - 8388608;
		kind = int'($urandom_range(0, 99));
		if (kind < 5) begin
			dx = 0;
			dy = 0;
		end else if (kind < 20) begin
			// Straddle the edge of the near box.
			dx = ($urandom_range(0, 1) ? 1 : -1) * (cur_radius - 1 + int'($urandom_range(0, 2)));
			dy = int'($urandom_range(0, 2 * cur_radius + 2)) - (cur_radius + 1);
			if ($urandom_range(0, 1)) begin
				kind = dx;
				dx = dy;
				dy = kind;
			end
		end else if (kind < 35) begin
			dx = int'($urandom_range(0, 131072)) - 65536;
			dy = 0;
			if ($urandom_range(0, 1)) begin
				dy = dx;
				dx = 0;
			end
		end else if (kind < 65) begin
			dx = int'($urandom_range(0, 131072)) - 65536;
			dy = int'($urandom_range(0, 131072)) - 65536;
		end else if (kind < 80) begin
			dx = int'($urandom_range(0, 2000)) - 1000;
			dy = int'($urandom_range(0, 2000)) - 1000;
		end else begin
			dx = int'($urandom_range(0, 16777215)) - 8388608 - cx;
			dy = int'($urandom_range(0, 16777215)) - 8388608 - cy;
		end
		tx = cx + dx;
		ty = cy + dy;
		if ($urandom_range(0, 99) < 85)
			yaw = int'($urandom_range(0, 2 * ANG_PI)) - ANG_PI;
		else
			yaw = int'($urandom_range(0, 65535)) - 32768;
		send_request(cx, cy, yaw, tx, ty);
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++)
			send_random_request();
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cur_x <= '0;
		req_ch.cur_y <= '0;
		req_ch.cur_yaw <= '0;
		req_ch.tgt_x <= '0;
		req_ch.tgt_y <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_YAW_STEP;
		cfg_wdata <= '0;
		hold_go <= 1'b0;
		tx_idle_pct = 10;
		rx_idle_pct = 54;
		cur_radius = 300;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset configuration.
		send_request(0, 0, 0, 0, 0);
		send_request(100, 200, -500, 100, 200);
		send_request(0, 0, 0, 0, 5000);
		send_request(0, 0, 0, 0, -5000);
		send_request(0, 0, 3000, 5000, 0);
		send_request(0, 0, 0, -5000, 0);
		send_request(0, 0, ANG_PI, 5000, 0);
		send_request(0, 0, 0, 3000, 4000);
		send_request(0, 0, 0, -3000, 4000);
		send_request(0, 0, 0, -3000, -4000);
		send_request(0, 0, 0, 3000, -4000);
		send_request(-8388608, 8388607, 32767, 8388607, -8388608);
		send_request(8388607, -8388608, -32768, -8388608, 8388607);
		send_request(-8388608, -8388608, -ANG_PI, 8388607, 8388607);
		send_request(0, 0, -25000, -5000, 0);
		send_request(0, 0, 819, 5000, 0);
		send_request(0, 0, 820, 5000, 0);
		send_request(1000, 1000, 1234, 1299, 701);
		send_request(1000, 1000, 1234, 1300, 1000);
		send_request(0, 0, 0, -299, -299);
		send_request(0, 0, 0, 1, 1);
		send_request(0, 0, 0, 8388607, 1);
		send_request(0, 0, 0, 1, 8388607);
		send_request(5, -7, 16000, 6, -7);

		drain_pipeline();
		set_config(0, 0);
		run_random(PHASE_ITEMS);

		drain_pipeline();
		set_config(16383 | (int'($urandom_range(0, 3)) << 14), 65535);
		tx_idle_pct = 54;
		rx_idle_pct = 10;
		run_random(PHASE_ITEMS);

		drain_pipeline();
		set_config(8192, 1);
		run_random(PHASE_ITEMS);

		drain_pipeline();
		set_config(1, 300);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		run_random(PHASE_ITEMS);

		drain_pipeline();
		set_config(int'($urandom_range(0, 16383)), int'($urandom_range(0, 2000)));
		run_random(PHASE_ITEMS);

		drain_pipeline();
		repeat (40) @(posedge clk);
		if (n_fail == 0 && n_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
